@@ rtl/fenwick_2d_range_add_point_query_top_assert.svh @@
// ----------------------------------------------------------------------------
// fenwick_2d_range_add_point_query_top_assert.svh
// assertion macros shared by the rtl of the 2-d fenwick tree block
// ----------------------------------------------------------------------------
`ifndef FENWICK_2D_RANGE_ADD_POINT_QUERY_TOP_ASSERT_SVH
`define FENWICK_2D_RANGE_ADD_POINT_QUERY_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge out of reset
`define FW2D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define FW2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FW2D_ASSERT(lbl, prop, msg)
`define FW2D_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/fw2d_pkg.sv @@
// ----------------------------------------------------------------------------
// fw2d_pkg
// shared types and constants of the 2-d fenwick tree block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fw2d_pkg;

    localparam int COORD_W  = 7;
    localparam int CORNER_W = 8;
    localparam int DELTA_W  = 32;
    localparam int VALUE_W  = 64;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    localparam logic [COORD_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [COORD_W-1:0] COLS_RESET = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_ROWS_IDX = 1'b0;
    localparam logic REG_COLS_IDX = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CORNER,
        ST_ADD_RUN,
        ST_ADD_DRAIN,
        ST_Q_SETUP,
        ST_Q_RUN,
        ST_Q_DRAIN,
        ST_Q_DONE
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic take_req;
        logic load_corner;
        logic next_corner;
        logic load_query;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic corner_ok;
        logic corner_last;
        logic query_ok;
        logic walk_last;
        logic out_free;
    } status_t;

endpackage

@@ rtl/fw2d_if.sv @@
// ----------------------------------------------------------------------------
// fw2d_if
// request and response channel interfaces of the 2-d fenwick tree block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fw2d_req_if;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [6:0]          row_lo;
    logic [6:0]          col_lo;
    logic [6:0]          row_hi;
    logic [6:0]          col_hi;
    logic signed [31:0]  delta;

    modport source (
        output valid, req_type, row_lo, col_lo, row_hi, col_hi, delta,
        input  ready
    );
    modport sink (
        input  valid, req_type, row_lo, col_lo, row_hi, col_hi, delta,
        output ready
    );
endinterface

interface fw2d_rsp_if;
    logic                valid;
    logic                ready;
    logic signed [63:0]  cell_value;

    modport source (
        output valid, cell_value,
        input  ready
    );
    modport sink (
        input  valid, cell_value,
        output ready
    );
endinterface

@@ rtl/fw2d_cfg.sv @@
// ----------------------------------------------------------------------------
// fw2d_cfg
// apb register file holding rows_in_use and cols_in_use
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fw2d_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fw2d_pkg::CFG_AW-1:0]    paddr,
    input  logic [fw2d_pkg::CFG_DW-1:0]    pwdata,
    output logic [fw2d_pkg::CFG_DW-1:0]    prdata,
    output logic                           pready,
    output logic [fw2d_pkg::COORD_W-1:0]   rows_in_use,
    output logic [fw2d_pkg::COORD_W-1:0]   cols_in_use
);
    import fw2d_pkg::*;

    logic                 wr_en;
    logic                 reg_idx;
    logic [COORD_W-1:0]   rows_reg;
    logic [COORD_W-1:0]   cols_reg;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ROWS_IDX: rows_reg <= pwdata[COORD_W-1:0];
                REG_COLS_IDX: cols_reg <= pwdata[COORD_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ROWS_IDX: prdata = {{(CFG_DW-COORD_W){1'b0}}, rows_reg};
            REG_COLS_IDX: prdata = {{(CFG_DW-COORD_W){1'b0}}, cols_reg};
        endcase
    end

    assign rows_in_use = rows_reg;
    assign cols_in_use = cols_reg;

endmodule

@@ rtl/fw2d_ctrl.sv @@
// ----------------------------------------------------------------------------
// fw2d_ctrl
// sequencer for clear sweep, corner updates and prefix-sum walks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fenwick_2d_range_add_point_query_top_assert.svh"

module fw2d_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_query,
    output logic                in_ready,
    output fw2d_pkg::cmd_t      cmd,
    input  fw2d_pkg::status_t   status
);
    import fw2d_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (status.clear_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid)
                    state_next = in_query ? ST_Q_SETUP : ST_CORNER;
            ST_CORNER:
                if (status.corner_ok)
                    state_next = ST_ADD_RUN;
                else if (status.corner_last)
                    state_next = ST_IDLE;
            ST_ADD_RUN:
                if (status.walk_last)
                    state_next = ST_ADD_DRAIN;
            ST_ADD_DRAIN:
                state_next = status.corner_last ? ST_IDLE : ST_CORNER;
            ST_Q_SETUP:
                state_next = status.query_ok ? ST_Q_RUN : ST_Q_DONE;
            ST_Q_RUN:
                if (status.walk_last)
                    state_next = ST_Q_DRAIN;
            ST_Q_DRAIN:
                state_next = ST_Q_DONE;
            ST_Q_DONE:
                if (status.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:     cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.take_req = in_valid;
            end
            ST_CORNER:
            begin
                cmd.load_corner = status.corner_ok;
                cmd.next_corner = !status.corner_ok && !status.corner_last;
            end
            ST_ADD_RUN:   cmd.step = 1'b1;
            ST_ADD_DRAIN: cmd.next_corner = !status.corner_last;
            ST_Q_SETUP:   cmd.load_query = 1'b1;
            ST_Q_RUN:     cmd.step = 1'b1;
            ST_Q_DRAIN:   cmd.step = 1'b0;
            ST_Q_DONE:    cmd.load_out = status.out_free;
            default:      cmd = '0;
        endcase
    end

    `FW2D_ASSERT_NEXT(a_take_dispatch, cmd.take_req, (state_reg == ST_CORNER || state_reg == ST_Q_SETUP), "request taken but no walk started")
    `FW2D_ASSERT(a_out_free, cmd.load_out |-> status.out_free, "result loaded over a pending result")
    `FW2D_ASSERT(a_drain_after_last, (state_reg == ST_ADD_DRAIN) |-> $past(status.walk_last), "corner walk ended early")

endmodule

@@ rtl/fw2d_datapath.sv @@
// ----------------------------------------------------------------------------
// fw2d_datapath
// tree memory, walk indices, read-modify-write pipe and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fenwick_2d_range_add_point_query_top_assert.svh"

module fw2d_datapath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fw2d_pkg::cmd_t                  cmd,
    output fw2d_pkg::status_t               status,
    input  logic [fw2d_pkg::COORD_W-1:0]    rows_in_use,
    input  logic [fw2d_pkg::COORD_W-1:0]    cols_in_use,
    input  logic                            req_type,
    input  logic [fw2d_pkg::COORD_W-1:0]    row_lo,
    input  logic [fw2d_pkg::COORD_W-1:0]    col_lo,
    input  logic [fw2d_pkg::COORD_W-1:0]    row_hi,
    input  logic [fw2d_pkg::COORD_W-1:0]    col_hi,
    input  logic signed [fw2d_pkg::DELTA_W-1:0] delta,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [fw2d_pkg::VALUE_W-1:0] cell_value
);
    import fw2d_pkg::*;

    localparam int RNW       = $clog2(MAX_ROWS + 1);
    localparam int CNW       = $clog2(MAX_COLS + 1);
    localparam int RIW       = RNW + 1;
    localparam int CIW       = CNW + 1;
    localparam int RKW       = (RIW > CORNER_W) ? RIW : CORNER_W;
    localparam int CKW       = (CIW > CORNER_W) ? CIW : CORNER_W;
    localparam int GridCols  = MAX_COLS + 1;
    localparam int GridCells = (MAX_ROWS + 1) * GridCols;
    localparam int AW        = $clog2(GridCells);

    // latched request
    logic                  req_query_reg;
    logic [COORD_W-1:0]    row_lo_reg;
    logic [COORD_W-1:0]    col_lo_reg;
    logic [COORD_W-1:0]    row_hi_reg;
    logic [COORD_W-1:0]    col_hi_reg;
    logic [DELTA_W-1:0]    delta_reg;
    logic [1:0]            corner_reg;

    // walk state
    logic [RIW-1:0]        i_reg;
    logic [CIW-1:0]        j_reg;
    logic [CIW-1:0]        c0_reg;
    logic [VALUE_W-1:0]    amt_reg;
    logic [VALUE_W-1:0]    acc_reg;

    // memory pipe
    logic [VALUE_W-1:0]    tree_mem [GridCells];
    logic                  rd_pend_reg;
    logic [AW-1:0]         wr_addr_reg;
    logic [VALUE_W-1:0]    rdata_reg;
    logic [AW-1:0]         clr_reg;

    logic                  out_valid_reg;
    logic [VALUE_W-1:0]    cell_value_reg;

    logic [RKW-1:0]        n_k;
    logic [CKW-1:0]        m_k;
    logic [RIW-1:0]        n;
    logic [CIW-1:0]        m;
    logic [CORNER_W-1:0]   corner_r;
    logic [CORNER_W-1:0]   corner_c;
    logic [VALUE_W-1:0]    d64;
    logic [VALUE_W-1:0]    corner_amt;
    logic [RKW-1:0]        q_r_k;
    logic [CKW-1:0]        q_c_k;
    logic [RIW-1:0]        q_r;
    logic [CIW-1:0]        q_c;
    logic [RIW-1:0]        lsb_i;
    logic [CIW-1:0]        lsb_j;
    logic [RIW-1:0]        i_step;
    logic [CIW-1:0]        j_step;
    logic                  row_wrap;
    logic                  walk_last;
    logic [RIW-1:0]        i_next;
    logic [CIW-1:0]        j_next;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_W-1:0]    wr_data;
    logic                  out_free;

    // effective grid size, register clamped to the built size
    assign n_k = (RKW'(rows_in_use) > RKW'(MAX_ROWS)) ? RKW'(MAX_ROWS) : RKW'(rows_in_use);
    assign m_k = (CKW'(cols_in_use) > CKW'(MAX_COLS)) ? CKW'(MAX_COLS) : CKW'(cols_in_use);
    assign n   = RIW'(n_k);
    assign m   = CIW'(m_k);

    // corner order: (lo,lo,+d) (lo,hi+1,-d) (hi+1,lo,-d) (hi+1,hi+1,+d)
    assign corner_r   = corner_reg[1] ? ({1'b0, row_hi_reg} + CORNER_W'(1))
                                      : {1'b0, row_lo_reg};
    assign corner_c   = corner_reg[0] ? ({1'b0, col_hi_reg} + CORNER_W'(1))
                                      : {1'b0, col_lo_reg};
    assign d64        = {{(VALUE_W-DELTA_W){delta_reg[DELTA_W-1]}}, delta_reg};
    assign corner_amt = (corner_reg[1] ^ corner_reg[0]) ? (~d64 + VALUE_W'(1)) : d64;

    // query point clamped into the grid
    assign q_r_k = (RKW'(row_lo_reg) > n_k) ? n_k : RKW'(row_lo_reg);
    assign q_c_k = (CKW'(col_lo_reg) > m_k) ? m_k : CKW'(col_lo_reg);
    assign q_r   = RIW'(q_r_k);
    assign q_c   = CIW'(q_c_k);

    // lowest set bit stepping: climb for updates, descend for sums
    assign lsb_i = i_reg & (~i_reg + RIW'(1));
    assign lsb_j = j_reg & (~j_reg + CIW'(1));

    always_comb
    begin
        if (req_query_reg)
        begin
            i_step    = i_reg - lsb_i;
            j_step    = j_reg - lsb_j;
            row_wrap  = (j_step == '0);
            walk_last = row_wrap && (i_step == '0);
        end
        else
        begin
            i_step    = i_reg + lsb_i;
            j_step    = j_reg + lsb_j;
            row_wrap  = (j_step > m);
            walk_last = row_wrap && (i_step > n);
        end
        i_next = row_wrap ? i_step : i_reg;
        j_next = row_wrap ? c0_reg : j_step;
    end

    assign rd_addr = AW'(i_reg * GridCols) + AW'(j_reg);
    assign wr_en   = cmd.clear_step || (rd_pend_reg && !req_query_reg);
    assign wr_addr = cmd.clear_step ? clr_reg : wr_addr_reg;
    assign wr_data = cmd.clear_step ? '0 : (rdata_reg + amt_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tree_mem[wr_addr] <= wr_data;
        if (cmd.step)
            rdata_reg <= tree_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.step;
            if (cmd.clear_step)
                clr_reg <= clr_reg + AW'(1);
            if (cmd.take_req)
                corner_reg <= '0;
            else if (cmd.next_corner)
                corner_reg <= corner_reg + 2'd1;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            req_query_reg <= req_type;
            row_lo_reg    <= row_lo;
            col_lo_reg    <= col_lo;
            row_hi_reg    <= row_hi;
            col_hi_reg    <= col_hi;
            delta_reg     <= delta;
        end
        if (cmd.load_corner)
        begin
            i_reg   <= RIW'(corner_r);
            j_reg   <= CIW'(corner_c);
            c0_reg  <= CIW'(corner_c);
            amt_reg <= corner_amt;
        end
        else if (cmd.load_query)
        begin
            i_reg  <= q_r;
            j_reg  <= q_c;
            c0_reg <= q_c;
        end
        else if (cmd.step)
        begin
            i_reg <= i_next;
            j_reg <= j_next;
        end
        if (cmd.step)
            wr_addr_reg <= rd_addr;
        if (cmd.load_query)
            acc_reg <= '0;
        else if (rd_pend_reg && req_query_reg)
            acc_reg <= acc_reg + rdata_reg;
        if (cmd.load_out)
            cell_value_reg <= acc_reg;
    end

    assign status.clear_last  = (clr_reg == AW'(GridCells - 1));
    assign status.corner_ok   = (corner_r != '0) && (corner_c != '0)
                             && (RKW'(corner_r) <= n_k) && (CKW'(corner_c) <= m_k);
    assign status.corner_last = (corner_reg == 2'd3);
    assign status.query_ok    = (q_r != '0) && (q_c != '0);
    assign status.walk_last   = walk_last;
    assign status.out_free    = out_free;

    assign out_valid  = out_valid_reg;
    assign cell_value = cell_value_reg;

    `FW2D_ASSERT(a_no_collision, (wr_en && cmd.step) |-> (wr_addr != rd_addr), "read and write hit one tree entry")
    `FW2D_ASSERT(a_walk_in_grid, cmd.step |-> (i_reg != '0 && j_reg != '0 && i_reg <= n && j_reg <= m), "walk left the grid")
    `FW2D_ASSERT(a_clear_quiet, cmd.clear_step |-> !rd_pend_reg, "update pending during clear sweep")

endmodule

@@ rtl/fenwick_2d_range_add_point_query_top.sv @@
// ----------------------------------------------------------------------------
// fenwick_2d_range_add_point_query_top
// 2-d fenwick tree with rectangle add and point query
//
// a rectangle-add transfer adds a signed 32-bit delta to every cell of
// rows row_lo..row_hi and columns col_lo..col_hi and gives no response; a
// point-query transfer returns the current 64-bit value of cell
// (row_lo, col_lo), wrapping modulo 2^64. the tree lives in one
// (MAX_ROWS+1)*(MAX_COLS+1) x 64 memory with one read and one write port.
// after reset the block sweeps that memory to zero, one entry a cycle, and
// takes no request until the sweep is done; apb writes are taken
// throughout. a rectangle add runs four corner walks, each a setup step,
// one tree entry touched per cycle (up to log2-bounded rows times columns,
// 7 x 7 at 64 x 64) and a drain step; corners outside the grid are skipped.
// a query has a setup step, a walk summing one entry per cycle (at most
// 6 x 6 entries, for row and column 63), a drain step and a result step.
// the walks and the read-modify-write pipe share the memory ports. the
// response sits in an output register, so the next request is taken while
// it waits.
// rows_in_use (0x0) and cols_in_use (0x4) must only be written while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fenwick_2d_range_add_point_query_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    fw2d_req_if.sink                       req,
    fw2d_rsp_if.source                     rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fw2d_pkg::CFG_AW-1:0]    paddr,
    input  logic [fw2d_pkg::CFG_DW-1:0]    pwdata,
    output logic [fw2d_pkg::CFG_DW-1:0]    prdata,
    output logic                           pready
);
    import fw2d_pkg::*;

    logic [COORD_W-1:0]  rows_in_use;
    logic [COORD_W-1:0]  cols_in_use;
    cmd_t                cmd;
    status_t             status;
    logic                in_ready;

    // configuration registers
    fw2d_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .rows_in_use (rows_in_use),
        .cols_in_use (cols_in_use)
    );

    // sequencer: clear sweep, corner walks, sum walks
    fw2d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_query (req.req_type),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // tree memory and arithmetic
    fw2d_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .rows_in_use (rows_in_use),
        .cols_in_use (cols_in_use),
        .req_type    (req.req_type),
        .row_lo      (req.row_lo),
        .col_lo      (req.col_lo),
        .row_hi      (req.row_hi),
        .col_hi      (req.col_hi),
        .delta       (req.delta),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .cell_value  (rsp.cell_value)
    );

    // request transfer only in idle
    assign req.ready = in_ready;

endmodule

@@ tb/tb_fenwick_2d_range_add_point_query_top.sv @@
// ----------------------------------------------------------------------------
// tb_fenwick_2d_range_add_point_query_top
// self-checking bench for the 2-d fenwick tree with rectangle add and point query
//
// a behavioral copy of the tree is kept in the bench and updated on every
// accepted rectangle add; each point query pushes its predicted cell value, and
// every response transfer is compared with the oldest prediction. directed
// corner cases come first, then random traffic over several grid sizes,
// including zero and above-maximum register values, under changing
// sender and receiver pacing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fenwick_2d_range_add_point_query_top;
    import fw2d_pkg::*;

    localparam int GRID_MAX_ROWS = 64;
    localparam int GRID_MAX_COLS = 64;
    localparam int CLK_PERIOD    = 10;
    // wait after the last answer, with margin over the worst rectangle add
    localparam int DRAIN_CYCLES  = 300;
    // watchdog limit on the whole run, clear sweep included
    localparam int CYCLE_LIMIT   = 1500000;

    localparam logic REQ_RECT_ADD    = 1'b0;
    localparam logic REQ_POINT_QUERY = 1'b1;

    typedef enum int {
        PACE_RX_STALLS,
        PACE_TX_GAPS,
        PACE_FULL_RATE
    } pace_t;

    typedef struct {
        logic                      req_type;
        logic [COORD_W-1:0]        row_lo;
        logic [COORD_W-1:0]        col_lo;
        logic [COORD_W-1:0]        row_hi;
        logic [COORD_W-1:0]        col_hi;
        logic signed [DELTA_W-1:0] delta;
    } grid_req_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    fw2d_req_if req_ch ();
    fw2d_rsp_if rsp_ch ();

    fenwick_2d_range_add_point_query_top #(
        .MAX_ROWS (GRID_MAX_ROWS),
        .MAX_COLS (GRID_MAX_COLS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the tree and the two grid-size registers
    logic [VALUE_W-1:0] tree_copy [0:GRID_MAX_ROWS][0:GRID_MAX_COLS];
    logic [COORD_W-1:0] rows_setting;
    logic [COORD_W-1:0] cols_setting;

    // predicted cell values of queries in flight, oldest first
    logic [VALUE_W-1:0] expected_cell_values [$];

    int fail_count     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    // ------------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    // registers above the tree size are clamped to it
    function automatic int active_rows();
        return (int'(rows_setting) > GRID_MAX_ROWS) ? GRID_MAX_ROWS : int'(rows_setting);
    endfunction

    function automatic int active_cols();
        return (int'(cols_setting) > GRID_MAX_COLS) ? GRID_MAX_COLS : int'(cols_setting);
    endfunction

    // one corner of the difference grid, climbing by lowest set bit
    function automatic void corner_update(int r, int c, logic [VALUE_W-1:0] amount);
        int n;
        int m;
        int i;
        int j;
        n = active_rows();
        m = active_cols();
        // zero coordinates and corners past the grid edge drop out
        if (r == 0 || c == 0 || r > n || c > m)
            return;
        for (i = r; i <= n; i += i & -i)
            for (j = c; j <= m; j += j & -j)
                tree_copy[i][j] += amount;
    endfunction

    // prefix sum up to (r, c) is the current value of that cell
    function automatic logic [VALUE_W-1:0] cell_prefix_sum(int r, int c);
        int n;
        int m;
        int i;
        int j;
        logic [VALUE_W-1:0] acc;
        n   = active_rows();
        m   = active_cols();
        acc = '0;
        if (r > n)
            r = n;
        if (c > m)
            c = m;
        if (r == 0 || c == 0)
            return acc;
        for (i = r; i != 0; i -= i & -i)
            for (j = c; j != 0; j -= j & -j)
                acc += tree_copy[i][j];
        return acc;
    endfunction

    // returns 1 when the request produces a cell value
    function automatic bit apply_grid_request(grid_req_t rq, output logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] amount;
        logic [VALUE_W-1:0] negated;
        value = '0;
        if (rq.req_type == REQ_POINT_QUERY)
        begin
            value = cell_prefix_sum(int'(rq.row_lo), int'(rq.col_lo));
            return 1'b1;
        end
        amount  = {{(VALUE_W - DELTA_W){rq.delta[DELTA_W-1]}}, rq.delta};
        negated = -amount;
        // hi + 1 in int so that 127 + 1 does not wrap to zero
        corner_update(int'(rq.row_lo),     int'(rq.col_lo),     amount);
        corner_update(int'(rq.row_lo),     int'(rq.col_hi) + 1, negated);
        corner_update(int'(rq.row_hi) + 1, int'(rq.col_lo),     negated);
        corner_update(int'(rq.row_hi) + 1, int'(rq.col_hi) + 1, amount);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // response side: random ready and the checker
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_cell_value
        logic [VALUE_W-1:0] want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_cell_values.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected cell_value transfer, expected none, actual %h",
                         $time, rsp_ch.cell_value);
            end
            else
            begin
                want = expected_cell_values.pop_front();
                if (rsp_ch.cell_value !== want)
                begin
                    fail_count++;
                    $display("%0t: cell_value mismatch, expected %h, actual %h",
                             $time, want, rsp_ch.cell_value);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    // entered and left just after a falling edge; valid stays high on return
    // so that a following transfer can go back to back
    task automatic send_request(grid_req_t rq);
        logic [VALUE_W-1:0] value;
        bit                 has_value;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.req_type = rq.req_type;
        req_ch.row_lo   = rq.row_lo;
        req_ch.col_lo   = rq.col_lo;
        req_ch.row_hi   = rq.row_hi;
        req_ch.col_hi   = rq.col_hi;
        req_ch.delta    = rq.delta;
        req_ch.valid    = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        has_value = apply_grid_request(rq, value);
        if (has_value)
            expected_cell_values.push_back(value);
        @(negedge clk);
    endtask

    // drop valid and hold off until every query has been answered
    task automatic wait_for_results();
        req_ch.valid = 1'b0;
        while (expected_cell_values.size() != 0)
            @(negedge clk);
    endtask

    // apb write: setup cycle, then access cycle
    task automatic write_register(logic idx, logic [COORD_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = CFG_DW'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_ROWS_IDX)
            rows_setting = value;
        else
            cols_setting = value;
    endtask

    // adds give no response, so after the last answer an add may still be
    // walking the tree; wait it out before touching the size registers
    task automatic configure_grid(logic [COORD_W-1:0] rows, logic [COORD_W-1:0] cols);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_register(REG_ROWS_IDX, rows);
        write_register(REG_COLS_IDX, cols);
    endtask

    task automatic set_pace(pace_t pace);
        case (pace)
            PACE_RX_STALLS:
            begin
                send_idle_pct = 20;
                recv_idle_pct = 52;
            end
            PACE_TX_GAPS:
            begin
                send_idle_pct = 52;
                recv_idle_pct = 20;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------
    function automatic grid_req_t make_add(int rl, int cl, int rh, int ch,
                                           logic [DELTA_W-1:0] d);
        grid_req_t rq;
        rq.req_type = REQ_RECT_ADD;
        rq.row_lo   = COORD_W'(rl);
        rq.col_lo   = COORD_W'(cl);
        rq.row_hi   = COORD_W'(rh);
        rq.col_hi   = COORD_W'(ch);
        rq.delta    = d;
        return rq;
    endfunction

    // unused fields of a query get junk so their bits toggle too
    function automatic grid_req_t make_query(int r, int c);
        grid_req_t rq;
        rq.req_type = REQ_POINT_QUERY;
        rq.row_lo   = COORD_W'(r);
        rq.col_lo   = COORD_W'(c);
        rq.row_hi   = COORD_W'($urandom_range(127, 0));
        rq.col_hi   = COORD_W'($urandom_range(127, 0));
        rq.delta    = $urandom;
        return rq;
    endfunction

    function automatic logic [DELTA_W-1:0] random_delta();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 60)
            return $urandom;
        if (roll < 80)
            return DELTA_W'($urandom_range(200, 0) - 100);
        case ($urandom_range(3, 0))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // mostly well-formed rectangles and in-grid queries, some raw noise
    function automatic grid_req_t random_request();
        int n;
        int m;
        int roll;
        int rl;
        int cl;
        n = active_rows();
        m = active_cols();
        // with a zero register still aim at the whole tree
        if (n == 0)
            n = GRID_MAX_ROWS;
        if (m == 0)
            m = GRID_MAX_COLS;
        roll = $urandom_range(99, 0);
        if (roll < 45)
            return make_query($urandom_range(n, 1), $urandom_range(m, 1));
        if (roll < 55)
            return make_query($urandom_range(127, 0), $urandom_range(127, 0));
        if (roll < 90)
        begin
            rl = $urandom_range(n, 1);
            cl = $urandom_range(m, 1);
            return make_add(rl, cl, $urandom_range(n, rl), $urandom_range(m, cl),
                            random_delta());
        end
        return make_add($urandom_range(127, 0), $urandom_range(127, 0),
                        $urandom_range(127, 0), $urandom_range(127, 0), random_delta());
    endfunction

    task automatic run_random_items(int count);
        repeat (count)
        begin
            // now and then let the block drain completely
            if ($urandom_range(59, 0) == 0)
                wait_for_results();
            send_request(random_request());
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // reset-size grid: cleared tree, full-grid and single-cell adds, zero and
    // out-of-range coordinates, inverted rectangle, extreme deltas
    task automatic test_directed_cases();
        set_pace(PACE_RX_STALLS);
        send_request(make_query(1, 1));
        send_request(make_query(64, 64));
        send_request(make_add(1, 1, 64, 64, 32'h7fff_ffff));
        send_request(make_add(1, 1, 1, 1, 32'h8000_0000));
        send_request(make_query(1, 1));
        send_request(make_query(64, 64));
        send_request(make_query(0, 5));
        send_request(make_query(5, 0));
        send_request(make_query(127, 127));
        // zero corner coordinates
        send_request(make_add(0, 0, 3, 3, 32'hffff_ffff));
        send_request(make_query(2, 2));
        // lo above hi, corners applied as computed
        send_request(make_add(10, 10, 5, 5, 32'd12345));
        send_request(make_query(7, 7));
        send_request(make_query(10, 10));
        // hi past the grid, far corners skipped
        send_request(make_add(63, 1, 127, 64, 32'h5555_5555));
        send_request(make_add(127, 127, 127, 127, 32'h1234_5678));
        send_request(make_query(65, 3));
        send_request(make_query(100, 100));
        send_request(make_query(64, 0));
        // hi of zero puts the closing corners on row and column one
        send_request(make_add(5, 5, 0, 0, 32'h2aaa_aaaa));
        send_request(make_query(1, 1));
        send_request(make_query(32, 32));
        send_request(make_query(64, 63));
    endtask

    task automatic test_full_grid_random();
        configure_grid(7'd64, 7'd64);
        run_random_items(300);
    endtask

    // single row, then single column
    task automatic test_narrow_grids();
        configure_grid(7'd1, 7'd64);
        run_random_items(60);
        set_pace(PACE_TX_GAPS);
        configure_grid(7'd64, 7'd1);
        run_random_items(60);
    endtask

    // registers above the tree size, then a zero register
    task automatic test_register_extremes();
        configure_grid(7'd127, 7'd65);
        run_random_items(250);
        configure_grid(7'd0, 7'd64);
        run_random_items(40);
    endtask

    task automatic test_random_sizes();
        set_pace(PACE_FULL_RATE);
        configure_grid(COORD_W'($urandom_range(64, 1)), COORD_W'($urandom_range(64, 1)));
        run_random_items(300);
        configure_grid(7'd64, 7'd64);
        run_random_items(240);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_RECT_ADD;
        req_ch.row_lo   = '0;
        req_ch.col_lo   = '0;
        req_ch.row_hi   = '0;
        req_ch.col_hi   = '0;
        req_ch.delta    = '0;
        rows_setting    = ROWS_RESET;
        cols_setting    = COLS_RESET;
        for (int i = 0; i <= GRID_MAX_ROWS; i++)
            for (int j = 0; j <= GRID_MAX_COLS; j++)
                tree_copy[i][j] = '0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // the block sweeps its memory first; the first transfer simply waits
        test_directed_cases();
        test_full_grid_random();
        test_narrow_grids();
        test_register_extremes();
        test_random_sizes();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/fw2d_pkg.sv
rtl/fw2d_if.sv
rtl/fw2d_cfg.sv
rtl/fw2d_ctrl.sv
rtl/fw2d_datapath.sv
rtl/fenwick_2d_range_add_point_query_top.sv
tb/tb_fenwick_2d_range_add_point_query_top.sv
